@@ hw/rtl/ple_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int PLE_CAPACITY = 32;
	localparam int PLE_DATA_W   = 32;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_ERASE  = 2'd1,
		FN_SORT   = 2'd2,
		FN_DUMP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_ENTRY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_COUNT,
		IDX_POS,
		IDX_ZERO,
		IDX_I,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_IDX_M1,
		RD_IDX_P1,
		RD_IDX,
		RD_I
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_CHK,
		S_INS_WR,
		S_ERS_CHK,
		S_ERS_WR,
		S_SRT_OUTER,
		S_SRT_LDV,
		S_SRT_CHK,
		S_SRT_CMP,
		S_DMP_RD,
		S_DMP_EMIT,
		S_RES_DONE,
		S_RES_RANGE,
		S_RES_FULL
	} ple_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    cap;
		idx_op_t idx_op;
		logic    i_one;
		logic    i_inc;
		logic    v_ld;
		rd_sel_t rd;
		logic    wr;
		logic    wr_v;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    out_ld;
		status_t st;
		logic    out_ent;
	} ple_cmd_t;

	// Status flags from the datapath to the controller.
	typedef struct packed {
		func_t func;
		logic  pos_gt_cnt;
		logic  pos_ge_cnt;
		logic  cnt_full;
		logic  cnt_zero;
		logic  idx_gt_pos;
		logic  idx_p1_lt_cnt;
		logic  idx_p1_eq_cnt;
		logic  idx_nz;
		logic  i_lt_cnt;
		logic  v_lt_rd;
		logic  out_free;
	} ple_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/ple_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_in_if
// Request channel of the positional list engine.
// ----------------------------------------------------------------------------
interface ple_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [5:0]         position;
	logic signed [31:0] value;

	modport source (output valid, func, position, value, input ready);
	modport sink   (input valid, func, position, value, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ple_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_out_if
// Result channel of the positional list engine.
// ----------------------------------------------------------------------------
interface ple_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] entry_value;
	logic [5:0]         count;
	logic               is_empty;
	logic               last;

	modport source (output valid, status, entry_value, count, is_empty, last, input ready);
	modport sink   (input valid, status, entry_value, count, is_empty, last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ple_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/ple_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ctrl
// Controller state machine: sequences insert, erase, sort and dump.
// ----------------------------------------------------------------------------
module ple_ctrl
	import ple_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire ple_stat_t stat,
	output ple_cmd_t       cmd
);
	ple_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (stat.func)
					FN_INSERT: begin
						if (stat.pos_gt_cnt) state_d = S_RES_RANGE;
						else if (stat.cnt_full) state_d = S_RES_FULL;
						else state_d = S_INS_CHK;
					end
					FN_ERASE: begin
						if (stat.pos_ge_cnt) state_d = S_RES_RANGE;
						else state_d = S_ERS_CHK;
					end
					FN_SORT: state_d = S_SRT_OUTER;
					default: begin
						if (stat.cnt_zero) state_d = S_RES_DONE;
						else state_d = S_DMP_RD;
					end
				endcase
			end
			S_INS_CHK: state_d = stat.idx_gt_pos ? S_INS_WR : S_RES_DONE;
			S_INS_WR: state_d = S_INS_CHK;
			S_ERS_CHK: state_d = stat.idx_p1_lt_cnt ? S_ERS_WR : S_RES_DONE;
			S_ERS_WR: state_d = S_ERS_CHK;
			S_SRT_OUTER: state_d = stat.i_lt_cnt ? S_SRT_LDV : S_RES_DONE;
			S_SRT_LDV: state_d = S_SRT_CHK;
			S_SRT_CHK: state_d = stat.idx_nz ? S_SRT_CMP : S_SRT_OUTER;
			S_SRT_CMP: state_d = stat.v_lt_rd ? S_SRT_CHK : S_SRT_OUTER;
			S_DMP_RD: state_d = S_DMP_EMIT;
			S_DMP_EMIT: begin
				if (stat.out_free) state_d = stat.idx_p1_eq_cnt ? S_IDLE : S_DMP_RD;
			end
			S_RES_DONE, S_RES_RANGE, S_RES_FULL: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.cap = in_valid;
			S_DECODE: begin
				case (stat.func)
					FN_INSERT: cmd.idx_op = IDX_COUNT;
					FN_ERASE: cmd.idx_op = IDX_POS;
					FN_SORT: cmd.i_one = 1'b1;
					default: cmd.idx_op = IDX_ZERO;
				endcase
			end
			S_INS_CHK: begin
				if (stat.idx_gt_pos) begin
					cmd.rd = RD_IDX_M1;
				end else begin
					cmd.wr      = 1'b1;
					cmd.wr_v    = 1'b1;
					cmd.cnt_inc = 1'b1;
				end
			end
			S_INS_WR: begin
				cmd.wr     = 1'b1;
				cmd.idx_op = IDX_DEC;
			end
			S_ERS_CHK: begin
				if (stat.idx_p1_lt_cnt) cmd.rd = RD_IDX_P1;
				else cmd.cnt_dec = 1'b1;
			end
			S_ERS_WR: begin
				cmd.wr     = 1'b1;
				cmd.idx_op = IDX_INC;
			end
			S_SRT_OUTER: begin
				if (stat.i_lt_cnt) cmd.rd = RD_I;
			end
			S_SRT_LDV: begin
				cmd.v_ld   = 1'b1;
				cmd.idx_op = IDX_I;
			end
			S_SRT_CHK: begin
				if (stat.idx_nz) begin
					cmd.rd = RD_IDX_M1;
				end else begin
					cmd.wr    = 1'b1;
					cmd.wr_v  = 1'b1;
					cmd.i_inc = 1'b1;
				end
			end
			S_SRT_CMP: begin
				cmd.wr = 1'b1;
				if (stat.v_lt_rd) begin
					cmd.idx_op = IDX_DEC;
				end else begin
					cmd.wr_v  = 1'b1;
					cmd.i_inc = 1'b1;
				end
			end
			S_DMP_RD: cmd.rd = RD_IDX;
			S_DMP_EMIT: begin
				if (stat.out_free) begin
					cmd.out_ld  = 1'b1;
					cmd.out_ent = 1'b1;
					cmd.st      = ST_ENTRY;
					cmd.idx_op  = IDX_INC;
				end
			end
			S_RES_DONE: begin
				cmd.out_ld = stat.out_free;
				cmd.st     = ST_DONE;
			end
			S_RES_RANGE: begin
				cmd.out_ld = stat.out_free;
				cmd.st     = ST_RANGE;
			end
			S_RES_FULL: begin
				cmd.out_ld = stat.out_free;
				cmd.st     = ST_FULL;
			end
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

@@ hw/rtl/ple_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_dp
// Datapath: entry RAM, count and index registers, result register.
// ----------------------------------------------------------------------------
module ple_dp
	import ple_pkg::*;
#(
	parameter int CAPACITY = PLE_CAPACITY
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         func,
	input  wire logic [5:0]         position,
	input  wire logic signed [31:0] value,
	input  wire ple_cmd_t           cmd,
	output ple_stat_t               stat,
	ple_out_if.source               rsp
);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int XW = (CW > 6) ? CW : 6;

	func_t              func_q;
	logic [5:0]         pos_q;
	logic signed [31:0] v_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      i_q;
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic signed [31:0] out_value_q;
	logic               out_last_q;
	logic [5:0]         out_count_q;
	logic               out_empty_q;

	logic [PLE_DATA_W-1:0] rd_data;
	logic [PLE_DATA_W-1:0] wr_data;
	logic [AW-1:0]         rd_addr;
	logic                  rd_en;
	logic [XW-1:0]         pos_x;
	logic [XW-1:0]         cnt_x;
	logic [CW:0]           idx_p1;

	assign pos_x  = XW'(pos_q);
	assign cnt_x  = XW'(count_q);
	assign idx_p1 = {1'b0, idx_q} + (CW+1)'(1);

	always_comb begin
		stat.func          = func_q;
		stat.pos_gt_cnt    = pos_x > cnt_x;
		stat.pos_ge_cnt    = pos_x >= cnt_x;
		stat.cnt_full      = count_q >= CW'(CAPACITY);
		stat.cnt_zero      = count_q == '0;
		stat.idx_gt_pos    = XW'(idx_q) > pos_x;
		stat.idx_p1_lt_cnt = idx_p1 < {1'b0, count_q};
		stat.idx_p1_eq_cnt = idx_p1 == {1'b0, count_q};
		stat.idx_nz        = idx_q != '0;
		stat.i_lt_cnt      = i_q < count_q;
		stat.v_lt_rd       = v_q < $signed(rd_data);
		stat.out_free      = !out_valid_q || rsp.ready;
	end

	always_comb begin
		case (cmd.rd)
			RD_IDX_M1: rd_addr = AW'(idx_q - CW'(1));
			RD_IDX_P1: rd_addr = AW'(idx_p1);
			RD_IDX:    rd_addr = AW'(idx_q);
			RD_I:      rd_addr = AW'(i_q);
			default:   rd_addr = '0;
		endcase
	end

	assign rd_en   = (cmd.rd != RD_NONE);
	assign wr_data = cmd.wr_v ? v_q : rd_data;

	ple_ram #(
		.WIDTH(PLE_DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(AW'(idx_q)),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q <= func_t'(func);
			pos_q  <= position;
		end
		if (cmd.cap) v_q <= value;
		else if (cmd.v_ld) v_q <= $signed(rd_data);
		case (cmd.idx_op)
			IDX_COUNT: idx_q <= count_q;
			IDX_POS:   idx_q <= CW'(pos_x);
			IDX_ZERO:  idx_q <= '0;
			IDX_I:     idx_q <= i_q;
			IDX_INC:   idx_q <= idx_q + CW'(1);
			IDX_DEC:   idx_q <= idx_q - CW'(1);
			default:   idx_q <= idx_q;
		endcase
		if (cmd.i_one) i_q <= CW'(1);
		else if (cmd.i_inc) i_q <= i_q + CW'(1);
		if (cmd.out_ld) begin
			out_status_q <= cmd.st;
			out_value_q  <= cmd.out_ent ? $signed(rd_data) : 32'sd0;
			out_last_q   <= cmd.out_ent ? stat.idx_p1_eq_cnt : 1'b1;
			out_count_q  <= 6'(count_q);
			out_empty_q  <= (count_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) count_q <= count_q + CW'(1);
			else if (cmd.cnt_dec) count_q <= count_q - CW'(1);
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// The count and the empty flag are captured with the result, because the
	// next request may already change the count while the result still waits.
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_value = out_value_q;
	assign rsp.count       = out_count_q;
	assign rsp.is_empty    = out_empty_q;
	assign rsp.last        = out_last_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY)) else $error("entry count above capacity");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.cnt_inc && cmd.cnt_dec)) else $error("count raised and lowered at once");
	a_wr_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (idx_q < CW'(CAPACITY))) else $error("write beyond the store");
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || rsp.ready)) else $error("pending result overwritten");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/positional_list_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with insert, erase, sort and dump.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req channel (func, position, value) and are
// accepted when valid and ready are both high. Results leave on the rsp
// channel; every request yields one result, except a dump of a non-empty
// list, which yields one result per entry with last set on the final one.
// One request is worked at a time; ready is high only while the engine is
// idle, and it may be high while a result still waits in the output register.
// A result is registered and becomes visible in the cycle after it is loaded;
// the next request is accepted in the cycle after the last load at the earliest.
// Reset clears the count, so the list starts empty; no clearing pass is run.
// When the receiver stalls the result register holds and the engine waits
// before loading the next result.
// ----------------------------------------------------------------------------
module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY = PLE_CAPACITY
) (
	input wire logic  clk,
	input wire logic  arst_n,
	ple_in_if.sink    req,
	ple_out_if.source rsp
);
	ple_cmd_t  cmd;
	ple_stat_t stat;

	ple_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ple_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.func    (req.func),
		.position(req.position),
		.value   (req.value),
		.cmd     (cmd),
		.stat    (stat),
		.rsp     (rsp)
	);
endmodule
`default_nettype wire

@@ bench/tb_positional_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Drives insert, erase, sort and dump requests into the list engine, keeps a
// shadow copy of the list to predict every result, and compares each result
// field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
	import ple_pkg::*;

	localparam int CAP = PLE_CAPACITY;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		status_t          status;
		logic signed [31:0] entry_value;
		logic [5:0]       count;
		logic             is_empty;
		logic             last;
	} list_result_t;

	logic clk;
	logic arst_n;

	ple_in_if  req ();
	ple_out_if rsp ();

	positional_list_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	logic signed [31:0] shadow_list [CAP];
	int                 shadow_count;
	list_result_t       pending_results [$];
	int                 error_count;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	bit                 recv_hold;
	int                 quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic list_result_t make_result(status_t st, logic signed [31:0] v,
			logic lst);
		list_result_t r;
		r.status      = st;
		r.entry_value = v;
		r.count       = shadow_count[5:0];
		r.is_empty    = (shadow_count == 0);
		r.last        = lst;
		return r;
	endfunction

	// Updates the shadow list and queues the results one request causes.
	task automatic predict_list_op(func_t fn, logic [5:0] pos, logic signed [31:0] val);
		logic signed [31:0] v;
		int j;
		case (fn)
			FN_INSERT: begin
				if (pos > shadow_count)
					pending_results.push_back(make_result(ST_RANGE, 0, 1'b1));
				else if (shadow_count >= CAP)
					pending_results.push_back(make_result(ST_FULL, 0, 1'b1));
				else begin
					for (int i = shadow_count; i > pos; i--)
						shadow_list[i] = shadow_list[i - 1];
					shadow_list[pos] = val;
					shadow_count++;
					pending_results.push_back(make_result(ST_DONE, 0, 1'b1));
				end
			end
			FN_ERASE: begin
				if (pos >= shadow_count)
					pending_results.push_back(make_result(ST_RANGE, 0, 1'b1));
				else begin
					for (int i = pos; i + 1 < shadow_count; i++)
						shadow_list[i] = shadow_list[i + 1];
					shadow_count--;
					pending_results.push_back(make_result(ST_DONE, 0, 1'b1));
				end
			end
			FN_SORT: begin
				for (int i = 1; i < shadow_count; i++) begin
					v = shadow_list[i];
					j = i;
					while (j > 0 && v < shadow_list[j - 1]) begin
						shadow_list[j] = shadow_list[j - 1];
						j--;
					end
					shadow_list[j] = v;
				end
				pending_results.push_back(make_result(ST_DONE, 0, 1'b1));
			end
			default: begin
				if (shadow_count == 0)
					pending_results.push_back(make_result(ST_DONE, 0, 1'b1));
				else
					for (int i = 0; i < shadow_count; i++)
						pending_results.push_back(make_result(ST_ENTRY, shadow_list[i],
							i + 1 == shadow_count));
			end
		endcase
	endtask

	// Valid stays high after an accept only until the next call decides to
	// idle or offers the next request, so each edge sees one assignment.
	task automatic send_request(func_t fn, logic [5:0] pos, logic signed [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.func     <= fn;
		req.position <= pos;
		req.value    <= val;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_list_op(fn, pos, val);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	function automatic logic signed [31:0] random_value();
		case ($urandom_range(5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(7)) - 3;
			default: return $urandom;
		endcase
	endfunction

	// Result checker.
	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0)
				report_mismatch("result with nothing expected");
			else begin
				exp_r = pending_results.pop_front();
				if (rsp.status !== exp_r.status)
					report_mismatch($sformatf("status %0d exp %0d", rsp.status, exp_r.status));
				if (rsp.entry_value !== exp_r.entry_value)
					report_mismatch($sformatf("entry_value %0d exp %0d", rsp.entry_value,
						exp_r.entry_value));
				if (rsp.count !== exp_r.count)
					report_mismatch($sformatf("count %0d exp %0d", rsp.count, exp_r.count));
				if (rsp.is_empty !== exp_r.is_empty)
					report_mismatch("is_empty differs");
				if (rsp.last !== exp_r.last)
					report_mismatch("last differs");
			end
		end
	end

	// Receiver stall pattern.
	always @(posedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog on cycles without any accepted request or result.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout");
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic test_directed_edges();
		send_request(FN_DUMP, 0, 0);
		send_request(FN_ERASE, 0, 0);
		send_request(FN_INSERT, 1, 5);
		send_request(FN_SORT, 0, 0);
		send_request(FN_INSERT, 0, 32'sh7FFFFFFF);
		send_request(FN_INSERT, 0, 32'sh80000000);
		send_request(FN_INSERT, 2, -1);
		send_request(FN_INSERT, 1, 0);
		send_request(FN_DUMP, 63, -1);
		send_request(FN_SORT, 63, -1);
		send_request(FN_DUMP, 0, 0);
		send_request(FN_ERASE, 4, 0);
		send_request(FN_ERASE, 63, 0);
		send_request(FN_ERASE, 3, 0);
		send_request(FN_ERASE, 0, 0);
		send_request(FN_DUMP, 0, 0);
		wait_drained();
	endtask

	task automatic test_full_list();
		while (shadow_count < CAP)
			send_request(FN_INSERT, $urandom_range(shadow_count), random_value());
		send_request(FN_INSERT, 0, 1);
		send_request(FN_INSERT, CAP, 1);
		send_request(FN_INSERT, 6'd63, 1);
		send_request(FN_DUMP, 0, 0);
		send_request(FN_SORT, 0, 0);
		send_request(FN_DUMP, 0, 0);
		send_request(FN_ERASE, CAP - 1, 0);
		send_request(FN_ERASE, 0, 0);
		wait_drained();
	endtask

	// The receiver holds off while requests keep coming so the engine stalls.
	task automatic test_backpressure();
		fork
			begin
				recv_hold = 1'b1;
				repeat (400) @(posedge clk);
				recv_hold = 1'b0;
			end
			begin
				repeat (12) send_request(func_t'($urandom_range(3)), $urandom_range(40),
					random_value());
				req.valid <= 1'b0;
			end
		join
		@(posedge clk);
		wait_drained();
	endtask

	task automatic test_random_ops(int n);
		func_t fn;
		int    r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 40) fn = FN_INSERT;
			else if (r < 70) fn = FN_ERASE;
			else if (r < 85) fn = FN_SORT;
			else fn = FN_DUMP;
			// Mostly in-range positions, sometimes anything the field holds.
			send_request(fn, ($urandom_range(9) == 0) ? 6'($urandom) :
				6'($urandom_range(shadow_count)), random_value());
		end
		wait_drained();
	endtask

	initial begin
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.func      = FN_INSERT;
		req.position  = '0;
		req.value     = '0;
		recv_hold     = 1'b0;
		error_count   = 0;
		shadow_count  = 0;
		send_idle_pct = 21;
		recv_idle_pct = 51;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_full_list();
		test_backpressure();
		test_random_ops(160);
		send_idle_pct = 51;
		recv_idle_pct = 21;
		test_random_ops(160);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_ops(160);

		repeat (100) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/ple_pkg.sv
hw/rtl/ple_in_if.sv
hw/rtl/ple_out_if.sv
hw/rtl/ple_ram.sv
hw/rtl/ple_ctrl.sv
hw/rtl/ple_dp.sv
hw/rtl/positional_list_engine.sv
bench/tb_positional_list_engine.sv
